### rtl/fcpid_pkg.sv
`default_nettype none

package fcpid_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 23;

  typedef enum logic [CFG_AW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_BOUND = 3'd3,
    REG_DRIVE_BOUND = 3'd4
  } reg_idx_t;

  localparam logic [15:0] RST_PROP_GAIN   = 16'd5500;
  localparam logic [15:0] RST_INTEG_GAIN  = 16'd800;
  localparam logic [15:0] RST_DERIV_GAIN  = 16'd0;
  localparam logic [22:0] RST_INTEG_BOUND = 23'd100000;
  localparam logic [14:0] RST_DRIVE_BOUND = 15'd1000;

  // Any |acc| past 100*32768 divides to more than the largest drive bound,
  // so the accumulator is clamped here before the divide by 100.
  localparam logic signed [43:0] ACC_CLAMP = 44'sd3276800;

  // floor(x/100) == (x * RECIP_MULT) >> RECIP_SHIFT for all x < 2^22
  localparam logic [22:0] RECIP_MULT  = 23'd5368710;
  localparam int          RECIP_SHIFT = 29;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [22:0] integ_bound;
    logic [14:0] drive_bound;
  } cfg_t;

  // error terms of one beat, handed from the state stage to the math stages
  typedef struct packed {
    logic [1:0]          channel;
    logic                oor;
    logic signed [17:0]  err;
    logic signed [23:0]  sum;
    logic signed [18:0]  der;
  } term_t;

endpackage

`default_nettype wire

### rtl/fcpid_cfg.sv
`default_nettype none

module fcpid_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fcpid_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [fcpid_pkg::CFG_DW-1:0] cfg_wdata,
  output fcpid_pkg::cfg_t                  cfg
);
  import fcpid_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_PROP_GAIN:   cfg_nxt.prop_gain   = cfg_wdata[15:0];
        REG_INTEG_GAIN:  cfg_nxt.integ_gain  = cfg_wdata[15:0];
        REG_DERIV_GAIN:  cfg_nxt.deriv_gain  = cfg_wdata[15:0];
        REG_INTEG_BOUND: cfg_nxt.integ_bound = cfg_wdata[22:0];
        REG_DRIVE_BOUND: cfg_nxt.drive_bound = cfg_wdata[14:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= RST_PROP_GAIN;
      cfg_r.integ_gain  <= RST_INTEG_GAIN;
      cfg_r.deriv_gain  <= RST_DERIV_GAIN;
      cfg_r.integ_bound <= RST_INTEG_BOUND;
      cfg_r.drive_bound <= RST_DRIVE_BOUND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/fcpid_front.sv
`default_nettype none

module fcpid_front #(
  parameter int CHANNELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_channel,
  input  wire logic signed [15:0] in_target_speed,
  input  wire logic signed [15:0] in_speed_offset,
  input  wire logic signed [15:0] in_measured_speed,
  input  wire fcpid_pkg::cfg_t    cfg,
  output logic                    term_valid,
  input  wire logic               term_ready,
  output fcpid_pkg::term_t        term
);
  import fcpid_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input register
  logic               v0_r;
  logic [1:0]         ch_r;
  logic signed [15:0] tgt_r;
  logic signed [15:0] off_r;
  logic signed [15:0] meas_r;

  // per-channel loop state
  logic signed [24:0] sum_mem_r  [CHANNELS];
  logic signed [17:0] last_mem_r [CHANNELS];

  term_t term_r;
  term_t term_nxt;
  logic  term_v_r;

  logic               en1;
  logic               move0;
  logic [IDX_W-1:0]   idx;
  logic signed [25:0] sum_raw;
  logic signed [25:0] bound;
  logic signed [25:0] sum_clamped;

  assign en1      = !term_v_r || term_ready;
  assign in_ready = !v0_r || en1;
  assign move0    = v0_r && en1;
  assign idx      = IDX_W'(ch_r);

  always_comb begin
    term_nxt.channel = ch_r;
    term_nxt.oor     = (32'(ch_r) >= CHANNELS);
    term_nxt.err     = 18'(tgt_r) + 18'(off_r) - 18'(meas_r);
    sum_raw          = 26'(sum_mem_r[idx]) + 26'(term_nxt.err);
    bound            = $signed({3'b000, cfg.integ_bound});
    if (sum_raw > bound) begin
      sum_clamped = bound;
    end else if (sum_raw < -bound) begin
      sum_clamped = -bound;
    end else begin
      sum_clamped = sum_raw;
    end
    term_nxt.sum = 24'(sum_clamped);
    term_nxt.der = 19'(term_nxt.err) - 19'(last_mem_r[idx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      term_v_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_mem_r[i]  <= '0;
        last_mem_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (en1) begin
        term_v_r <= v0_r;
      end
      // state moves on as the beat leaves the input register
      if (move0 && !term_nxt.oor) begin
        sum_mem_r[idx]  <= 25'(term_nxt.sum);
        last_mem_r[idx] <= term_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ch_r   <= in_channel;
      tgt_r  <= in_target_speed;
      off_r  <= in_speed_offset;
      meas_r <= in_measured_speed;
    end
    if (en1) begin
      term_r <= term_nxt;
    end
  end

  assign term_valid = term_v_r;
  assign term       = term_r;

`ifndef SYNTHESIS
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v0_r && term_v_r))
    else $error("input stalled with a free stage");
  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    term_v_r |-> (term_r.sum != -24'sd8388608))
    else $error("clamped error sum out of range");
  a_term_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (term_v_r && !term_ready) |=> (term_v_r && $stable(term_r)))
    else $error("stalled term beat changed");
`endif

endmodule

`default_nettype wire

### rtl/fcpid_mac.sv
`default_nettype none

module fcpid_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fcpid_pkg::cfg_t    cfg,
  input  wire logic               term_valid,
  output logic                    term_ready,
  input  wire fcpid_pkg::term_t   term,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_channel,
  output logic signed [15:0]      out_drive
);
  import fcpid_pkg::*;

  // products stage
  logic               v2_r;
  logic [1:0]         ch2_r;
  logic               oor2_r;
  logic signed [34:0] p_prop_r;
  logic signed [41:0] p_integ_r;
  logic signed [35:0] p_deriv_r;
  logic signed [34:0] p_prop_nxt;
  logic signed [41:0] p_integ_nxt;
  logic signed [35:0] p_deriv_nxt;

  // sum, clamp and magnitude stage
  logic               v3_r;
  logic [1:0]         ch3_r;
  logic               oor3_r;
  logic               neg3_r;
  logic [21:0]        mag3_r;
  logic signed [43:0] acc;
  logic signed [43:0] acc_clamped;
  logic               neg3_nxt;
  logic [21:0]        mag3_nxt;

  // reciprocal multiply stage
  logic               v4_r;
  logic [1:0]         ch4_r;
  logic               oor4_r;
  logic               neg4_r;
  logic [44:0]        prod4_r;
  logic [44:0]        prod4_nxt;

  // result register
  logic               out_valid_r;
  logic [1:0]         out_ch_r;
  logic signed [15:0] out_drive_r;
  logic signed [15:0] drive_nxt;
  logic [15:0]        quot;
  logic signed [16:0] quot_s;
  logic signed [16:0] dbound;

  logic e2, e3, e4, eo;

  assign eo         = !out_valid_r || out_ready;
  assign e4         = !v4_r || eo;
  assign e3         = !v3_r || e4;
  assign e2         = !v2_r || e3;
  assign term_ready = e2;

  assign p_prop_nxt  = $signed({1'b0, cfg.prop_gain}) * term.err;
  assign p_integ_nxt = $signed({1'b0, cfg.integ_gain}) * term.sum;
  assign p_deriv_nxt = $signed({1'b0, cfg.deriv_gain}) * term.der;

  always_comb begin
    acc = 44'(p_prop_r) + 44'(p_integ_r) + 44'(p_deriv_r);
    if (acc > ACC_CLAMP) begin
      acc_clamped = ACC_CLAMP;
    end else if (acc < -ACC_CLAMP) begin
      acc_clamped = -ACC_CLAMP;
    end else begin
      acc_clamped = acc;
    end
    neg3_nxt = acc_clamped[43];
    mag3_nxt = neg3_nxt ? 22'(-acc_clamped) : 22'(acc_clamped);
  end

  assign prod4_nxt = 45'(mag3_r) * 45'(RECIP_MULT);

  always_comb begin
    quot   = 16'(prod4_r >> RECIP_SHIFT);
    quot_s = neg4_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    dbound = $signed({2'b00, cfg.drive_bound});
    if (oor4_r) begin
      drive_nxt = '0;
    end else if (quot_s > dbound) begin
      drive_nxt = 16'(dbound);
    end else if (quot_s < -dbound) begin
      drive_nxt = 16'(-dbound);
    end else begin
      drive_nxt = 16'(quot_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (e2) v2_r <= term_valid;
      if (e3) v3_r <= v2_r;
      if (e4) v4_r <= v3_r;
      if (eo) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      ch2_r     <= term.channel;
      oor2_r    <= term.oor;
      p_prop_r  <= p_prop_nxt;
      p_integ_r <= p_integ_nxt;
      p_deriv_r <= p_deriv_nxt;
    end
    if (e3) begin
      ch3_r  <= ch2_r;
      oor3_r <= oor2_r;
      neg3_r <= neg3_nxt;
      mag3_r <= mag3_nxt;
    end
    if (e4) begin
      ch4_r   <= ch3_r;
      oor4_r  <= oor3_r;
      neg4_r  <= neg3_r;
      prod4_r <= prod4_nxt;
    end
    if (eo) begin
      out_ch_r    <= ch4_r;
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_drive   = out_drive_r;

`ifndef SYNTHESIS
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ((prod4_r >> RECIP_SHIFT) <= 45'd32768))
    else $error("quotient past clamped range");
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_r != -16'sd32768))
    else $error("drive value outside symmetric range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(out_drive_r) && $stable(out_ch_r)))
    else $error("stalled result beat changed");
`endif

endmodule

`default_nettype wire

### rtl/four_channel_pid_speed_loop_unit.sv
// Four-channel PID speed loop.
// Input channel (in_valid/in_ready): one beat per control update of one
// motor channel: channel index, target speed, speed offset, measured speed.
// Result channel (out_valid/out_ready): one beat per input beat, in order,
// carrying the channel index and the clamped signed drive value.
// Config port (cfg_we/cfg_addr/cfg_wdata): single-cycle register writes,
// index 0..4 = prop gain, integ gain, deriv gain, integral bound, drive
// bound; other indexes are dropped. Write only while the loop is empty.
// Throughput: one beat per cycle unless out_ready stalls. Each channel's
// error sum and last error are read and updated in the stage right after
// the input register, so same-channel beats may follow back to back.
// Path: an input beat that is taken passes the input reg, state/error,
// products, sum+clamp and reciprocal multiply stages to the result reg.
// Receiver stall: every stage has its own valid bit, so bubbles fill up
// before in_ready drops; six full stages and a low out_ready pull it low.
// Reset (rst_n low, synchronous): gains and bounds go to their defaults,
// all channel state clears to zero, and the pipeline empties.
// A channel index at or above CHANNELS leaves state alone and yields 0.
`default_nettype none

module four_channel_pid_speed_loop_unit #(
  parameter int CHANNELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // config writes
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_addr,
  input  wire logic [22:0]        cfg_wdata,
  // input beats
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_channel,
  input  wire logic signed [15:0] in_target_speed,
  input  wire logic signed [15:0] in_speed_offset,
  input  wire logic signed [15:0] in_measured_speed,
  // result beats
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_channel,
  output logic signed [15:0]      out_drive
);
  import fcpid_pkg::*;

  cfg_t  cfg;
  term_t term;
  logic  term_valid;
  logic  term_ready;

  fcpid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register plus per-channel state update
  fcpid_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel        (in_channel),
    .in_target_speed   (in_target_speed),
    .in_speed_offset   (in_speed_offset),
    .in_measured_speed (in_measured_speed),
    .cfg               (cfg),
    .term_valid        (term_valid),
    .term_ready        (term_ready),
    .term              (term)
  );

  // gain products, divide by 100, output clamp
  fcpid_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .term_valid  (term_valid),
    .term_ready  (term_ready),
    .term        (term),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_drive   (out_drive)
  );

endmodule

`default_nettype wire

### bench/tb_four_channel_pid_speed_loop_unit.sv
`timescale 1ns / 1ps

module tb_four_channel_pid_speed_loop_unit;
  import fcpid_pkg::*;

  localparam int CHANNELS    = 4;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 240;

  // how the gains and bounds get picked at the start of a phase
  typedef enum int {
    TUNE_DEFAULT,
    TUNE_TAME,
    TUNE_WILD
  } tune_t;

  // one expected result beat
  typedef struct packed {
    logic [1:0]         ch;
    logic signed [15:0] drive;
  } drive_beat_t;

  // Scoreboard: keeps its own copy of the gains and of each channel's
  // error sum / last error, predicts the drive of every accepted input
  // beat and matches result beats against those predictions in order.
  class drive_scoreboard;
    cfg_t               gains;
    logic signed [24:0] error_sum [CHANNELS];
    logic signed [17:0] last_error [CHANNELS];
    drive_beat_t        drive_q [$];
    int                 fail_count;

    function new();
      gains = '{prop_gain: RST_PROP_GAIN, integ_gain: RST_INTEG_GAIN,
                deriv_gain: RST_DERIV_GAIN, integ_bound: RST_INTEG_BOUND,
                drive_bound: RST_DRIVE_BOUND};
      foreach (error_sum[i]) begin
        error_sum[i]  = '0;
        last_error[i] = '0;
      end
      fail_count = 0;
    endfunction

    // data is cut to the register's width; unknown indexes drop the write
    function void write_reg(logic [2:0] idx, logic [22:0] val);
      case (idx)
        REG_PROP_GAIN:   gains.prop_gain   = val[15:0];
        REG_INTEG_GAIN:  gains.integ_gain  = val[15:0];
        REG_DERIV_GAIN:  gains.deriv_gain  = val[15:0];
        REG_INTEG_BOUND: gains.integ_bound = val[22:0];
        REG_DRIVE_BOUND: gains.drive_bound = val[14:0];
        default: ;
      endcase
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_beat(logic [1:0] ch, logic signed [15:0] tgt,
                            logic signed [15:0] off, logic signed [15:0] meas);
      drive_beat_t exp_beat;
      longint      err;
      longint      sum;
      longint      der;
      longint      acc;
      exp_beat.ch    = ch;
      exp_beat.drive = '0;
      // a channel past the last one leaves state alone and drives zero
      if (ch < CHANNELS) begin
        err = longint'(tgt) + longint'(off) - longint'(meas);
        sum = clamp_sym(longint'(error_sum[ch]) + err, longint'(gains.integ_bound));
        der = err - longint'(last_error[ch]);
        acc = longint'(gains.prop_gain) * err + longint'(gains.integ_gain) * sum
            + longint'(gains.deriv_gain) * der;
        // longint divide truncates toward zero
        exp_beat.drive = 16'(clamp_sym(acc / 100, longint'(gains.drive_bound)));
        error_sum[ch]  = 25'(sum);
        last_error[ch] = 18'(err);
      end
      drive_q.push_back(exp_beat);
    endfunction

    task report(string what);
      fail_count++;
      $display("%0t: %s", $time, what);
    endtask

    task check_result(logic [1:0] ch, logic signed [15:0] drv);
      drive_beat_t exp_beat;
      if (drive_q.size() == 0) begin
        report($sformatf("drive beat ch %0d drive %0d with nothing pending", ch, drv));
      end else begin
        exp_beat = drive_q.pop_front();
        if (ch !== exp_beat.ch)
          report($sformatf("channel %0d, want %0d", ch, exp_beat.ch));
        if (drv !== exp_beat.drive)
          report($sformatf("ch %0d drive %0d, want %0d", ch, drv, exp_beat.drive));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                cfg_we            = 1'b0;
  logic [2:0]          cfg_addr          = '0;
  logic [22:0]         cfg_wdata         = '0;
  logic                in_valid          = 1'b0;
  logic                in_ready;
  logic [1:0]          in_channel        = '0;
  logic signed [15:0]  in_target_speed   = '0;
  logic signed [15:0]  in_speed_offset   = '0;
  logic signed [15:0]  in_measured_speed = '0;
  logic                out_valid;
  logic                out_ready         = 1'b0;
  logic [1:0]          out_channel;
  logic signed [15:0]  out_drive;

  drive_scoreboard sb;

  // idle / stall switches, flipped per phase by the stimulus process
  bit sender_idles    = 1'b0;
  bit receiver_stalls = 1'b0;
  int stall_left      = 0;

  four_channel_pid_speed_loop_unit #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel       (in_channel),
    .in_target_speed  (in_target_speed),
    .in_speed_offset  (in_speed_offset),
    .in_measured_speed(in_measured_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .out_drive        (out_drive)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop, set well past the slowest legal run of roughly 2k beats,
  // each with the longest idle and stall bursts.
  initial begin
    #2_400_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check every accepted beat, then decide out_ready for the
  // next cycle. Stalls, when enabled, start on a 20% draw per free cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_channel, out_drive);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one beat and hold it until taken. in_valid stays high into the
  // next beat unless an idle burst is drawn.
  task automatic push_beat(input logic [1:0] ch, input logic signed [15:0] tgt,
                           input logic signed [15:0] off,
                           input logic signed [15:0] meas);
    in_valid          <= 1'b1;
    in_channel        <= ch;
    in_target_speed   <= tgt;
    in_speed_offset   <= off;
    in_measured_speed <= meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(ch, tgt, off, meas);
    if (sender_idles && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Near-setpoint speeds in four of ten beats so the drive lands inside its
  // clamp and the truncation shows; the rest medium or full-range noise.
  task automatic push_random_beat();
    logic signed [15:0] tgt;
    logic signed [15:0] off;
    logic signed [15:0] meas;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        tgt  = 16'(int'($urandom_range(0, 4000)) - 2000);
        off  = 16'(int'($urandom_range(0, 200)) - 100);
        meas = 16'(int'(tgt) + int'(off) + int'($urandom_range(0, 60)) - 30);
      end
      4, 5, 6: begin
        tgt  = 16'(int'($urandom_range(0, 6000)) - 3000);
        off  = 16'(int'($urandom_range(0, 6000)) - 3000);
        meas = 16'(int'($urandom_range(0, 6000)) - 3000);
      end
      default: begin
        tgt  = 16'($urandom);
        off  = 16'($urandom);
        meas = 16'($urandom);
      end
    endcase
    push_beat(2'($urandom_range(0, 3)), tgt, off, meas);
  endtask

  // One register write; cfg_we drops for a cycle after each write.
  task automatic load_reg(input logic [2:0] idx, input logic [22:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Every beat yields exactly one result, so an empty queue means the
  // pipeline is empty and the registers may be touched.
  task automatic wait_drained();
    int spins;
    spins = 0;
    while (sb.drive_q.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
  endtask

  task automatic tune_loop(input tune_t mode);
    case (mode)
      TUNE_DEFAULT: begin
        load_reg(REG_PROP_GAIN,   23'(RST_PROP_GAIN));
        load_reg(REG_INTEG_GAIN,  23'(RST_INTEG_GAIN));
        load_reg(REG_DERIV_GAIN,  23'(RST_DERIV_GAIN));
        load_reg(REG_INTEG_BOUND, 23'(RST_INTEG_BOUND));
        load_reg(REG_DRIVE_BOUND, 23'(RST_DRIVE_BOUND));
      end
      TUNE_TAME: begin
        load_reg(REG_PROP_GAIN,   23'($urandom_range(0, 10000)));
        load_reg(REG_INTEG_GAIN,  23'($urandom_range(0, 3000)));
        load_reg(REG_DERIV_GAIN,  23'($urandom_range(0, 3000)));
        load_reg(REG_INTEG_BOUND, 23'($urandom_range(0, 200000)));
        load_reg(REG_DRIVE_BOUND, 23'($urandom_range(0, 32767)));
      end
      default: begin
        // zero, all ones (cut to width) or any 23-bit pattern
        for (int r = int'(REG_PROP_GAIN); r <= int'(REG_DRIVE_BOUND); r++) begin
          case ($urandom_range(0, 2))
            0:       load_reg(3'(r), '0);
            1:       load_reg(3'(r), '1);
            default: load_reg(3'(r), 23'($urandom));
          endcase
        end
      end
    endcase
    // now and then a write to an index past the last register
    if ($urandom_range(0, 1))
      load_reg(3'(REG_DRIVE_BOUND) + 3'($urandom_range(1, 3)), 23'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset gains ----
    receiver_stalls = 1'b1;
    push_beat(2'd0, 16'sd0, 16'sd0, 16'sd0);
    // largest positive error, twice: drive pins high, sum hits its bound
    push_beat(2'd1, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_beat(2'd1, 16'sh7fff, 16'sh7fff, 16'sh8000);
    // most negative error, twice
    push_beat(2'd2, 16'sh8000, 16'sh8000, 16'sh7fff);
    push_beat(2'd2, 16'sh8000, 16'sh8000, 16'sh7fff);
    // small errors of both signs, drive inside the clamp
    push_beat(2'd3, 16'sd100, 16'sd0, 16'sd90);
    push_beat(2'd3, 16'sd100, -16'sd20, 16'sd90);
    push_beat(2'd0, 16'sd0, -16'sd7, 16'sd0);
    push_beat(2'd3, 16'sh7fff, 16'sd0, 16'sh7fff);

    // all gains and bounds at their top, data wider than the registers
    in_valid <= 1'b0;
    wait_drained();
    load_reg(REG_PROP_GAIN,   '1);
    load_reg(REG_INTEG_GAIN,  '1);
    load_reg(REG_DERIV_GAIN,  '1);
    load_reg(REG_INTEG_BOUND, '1);
    load_reg(REG_DRIVE_BOUND, '1);
    // full swings on one channel: largest derivative both ways
    push_beat(2'd0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_beat(2'd0, 16'sh8000, 16'sh8000, 16'sh7fff);
    push_beat(2'd0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_beat(2'd1, 16'sd0, 16'sd0, 16'sd0);

    // everything zero: sum clamps to 0, drive clamps to 0
    in_valid <= 1'b0;
    wait_drained();
    load_reg(REG_PROP_GAIN,   '0);
    load_reg(REG_INTEG_GAIN,  '0);
    load_reg(REG_DERIV_GAIN,  '0);
    load_reg(REG_INTEG_BOUND, '0);
    load_reg(REG_DRIVE_BOUND, '0);
    push_beat(2'd2, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_beat(2'd3, 16'sh8000, 16'sh8000, 16'sh7fff);

    // writes past the last register must not disturb anything
    in_valid <= 1'b0;
    wait_drained();
    for (int k = 1; k <= 3; k++) load_reg(3'(REG_DRIVE_BOUND) + 3'(k), '1);
    push_beat(2'd1, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_beat(2'd1, 16'sd5, 16'sd5, -16'sd5);

    // ---- random phases; each starts from an empty pipeline ----
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      if (ph == 0 || ph == PHASES - 1) tune_loop(TUNE_DEFAULT);
      else if (ph % 3 == 2) tune_loop(TUNE_WILD);
      else tune_loop(TUNE_TAME);
      // one phase without sender gaps, one without stalls, last one clean
      sender_idles    = (ph != 3) && (ph != PHASES - 1);
      receiver_stalls = (ph != 4) && (ph != PHASES - 1);
      for (int n = 0; n < PHASE_BEATS; n++) push_random_beat();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.drive_q.size() != 0)
      sb.report($sformatf("%0d drive beats never came out", sb.drive_q.size()));
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fcpid_pkg.sv
rtl/fcpid_cfg.sv
rtl/fcpid_front.sv
rtl/fcpid_mac.sv
rtl/four_channel_pid_speed_loop_unit.sv
bench/tb_four_channel_pid_speed_loop_unit.sv
